// ----- src/ihex_pkg.sv -----
// Shared constants and widths for the Intel HEX record loader.
package ihex_pkg;

	// Size of the memory image in bytes; the loader works for 256 up to 131072.
	localparam int IMAGE_BYTES = 131072;

	// Field widths of the result word.
	localparam int ADDR_W = 17;
	localparam int LEN_W  = 18;

	localparam logic [LEN_W-1:0] IMAGE_LEN = LEN_W'(IMAGE_BYTES);

	// Request codes on the character channel.
	localparam logic [1:0] REQ_CHAR  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_EOF   = 2'd2;

	// Result kinds.
	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_RECORD   = 3'd1;
	localparam logic [2:0] KIND_CSUM_ERR = 3'd2;
	localparam logic [2:0] KIND_HIGH_SEG = 3'd3;
	localparam logic [2:0] KIND_END      = 3'd4;

	// Record types that the loader acts on.
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EXT_LIN = 8'h04;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHAR_NL    = 8'h0a;
	localparam logic [7:0] CHAR_COLON = 8'h3a;

endpackage

// ----- src/ihex_if.sv -----
// Valid/ready channels for the character stream and the result stream.
interface ihex_char_if import ihex_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_in;

	modport source (output valid, output req_type, output char_in, input ready);
	modport sink (input valid, input req_type, input char_in, output ready);
endinterface

interface ihex_result_if import ihex_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [ADDR_W-1:0] write_addr;
	logic [7:0]        write_data;
	logic              out_of_range;
	logic [LEN_W-1:0]  image_length;

	modport source (output valid, output kind, output write_addr, output write_data,
		output out_of_range, output image_length, input ready);
	modport sink (input valid, input kind, input write_addr, input write_data,
		input out_of_range, input image_length, output ready);
endinterface

// ----- src/intel_hex_record_loader.sv -----
// Intel HEX record loader: parses a character stream into image byte writes and record, error and end results.
// Each result is registered: it appears in the output register in the cycle after its word is accepted.
// Throughput: one word per cycle; the parse state updates in the accept cycle.
// The input is held off only while a finished result waits and the sink is not ready.
// Reset (arst_n low, asynchronous) returns to line start with all state cleared and
// the result register empty; a start request clears the state the same way and emits no result.
module intel_hex_record_loader
	import ihex_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ihex_char_if.sink     chars,
	ihex_result_if.source results
);

	typedef enum logic [3:0] {
		PH_LINE_START,
		PH_SKIP,
		PH_COUNT,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_TYPE,
		PH_DATA,
		PH_CHECK
	} phase_t;

	// Architectural parse state.
	phase_t            phase_q;
	logic              low_nib_q;
	logic [7:0]        byte_q;
	logic [7:0]        sum_q;
	logic [7:0]        len_q;
	logic [15:0]       addr_q;
	logic [7:0]        rkind_q;
	logic [7:0]        seen_q;
	logic [15:0]       seg_q;
	logic [LEN_W-1:0]  wp_q;
	logic              halted_q;

	// Result register.
	logic              res_valid_q;
	logic [2:0]        res_kind_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [7:0]        res_data_q;
	logic              res_oor_q;
	logic [LEN_W-1:0]  res_len_q;

	// Next state and the result of the word at the input.
	phase_t            phase_d;
	logic              low_nib_d;
	logic [7:0]        byte_d;
	logic [7:0]        sum_d;
	logic [7:0]        len_d;
	logic [15:0]       addr_d;
	logic [7:0]        rkind_d;
	logic [7:0]        seen_d;
	logic [15:0]       seg_d;
	logic [LEN_W-1:0]  wp_d;
	logic              halted_d;

	logic              emit;
	logic [2:0]        emit_kind;
	logic [ADDR_W-1:0] emit_addr;
	logic [7:0]        emit_data;
	logic              emit_oor;

	logic [3:0]        nib;
	logic [7:0]        full_byte;
	logic [31:0]       target;
	logic [LEN_W-1:0]  target_clamped;
	logic [7:0]        seen_inc;
	logic              accept;

	// The input is taken whenever the result register is free or is being emptied,
	// so a waiting result never blocks a word that the sink is about to drain.
	assign chars.ready = !res_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;

	// Hex digit decode; any other character contributes its low four bits.
	always_comb begin
		unique case (chars.char_in) inside
			[8'h30:8'h39]: nib = chars.char_in[3:0];
			[8'h41:8'h46], [8'h61:8'h66]: nib = chars.char_in[3:0] + 4'd9;
			default: nib = chars.char_in[3:0];
		endcase
	end

	// The high nibble of a byte was kept in the low half of the byte accumulator.
	assign full_byte = {byte_q[3:0], nib};
	assign seen_inc  = seen_q + 8'd1;

	// Data record base address, clamped to the image size.
	assign target         = {seg_q, addr_q};
	assign target_clamped = (target > 32'(IMAGE_BYTES)) ? IMAGE_LEN : target[LEN_W-1:0];

	always_comb begin
		phase_d   = phase_q;
		low_nib_d = low_nib_q;
		byte_d    = byte_q;
		sum_d     = sum_q;
		len_d     = len_q;
		addr_d    = addr_q;
		rkind_d   = rkind_q;
		seen_d    = seen_q;
		seg_d     = seg_q;
		wp_d      = wp_q;
		halted_d  = halted_q;
		emit      = 1'b0;
		emit_kind = KIND_RECORD;
		emit_addr = '0;
		emit_data = '0;
		emit_oor  = 1'b0;

		if (chars.req_type == REQ_START) begin
			// Start of a new file clears all parse state, as reset does.
			phase_d   = PH_LINE_START;
			low_nib_d = 1'b0;
			byte_d    = '0;
			sum_d     = '0;
			len_d     = '0;
			addr_d    = '0;
			rkind_d   = '0;
			seen_d    = '0;
			seg_d     = '0;
			wp_d      = '0;
			halted_d  = 1'b0;
		end else if (chars.req_type == REQ_EOF) begin
			// End of file drops a record in progress and reports the length,
			// even when the loader is halted.
			phase_d   = PH_LINE_START;
			low_nib_d = 1'b0;
			emit      = 1'b1;
			emit_kind = KIND_END;
		end else if (chars.req_type == REQ_CHAR && !halted_q) begin
			if (chars.char_in == CHAR_NL) begin
				phase_d   = PH_LINE_START;
				low_nib_d = 1'b0;
			end else if (phase_q == PH_LINE_START) begin
				if (chars.char_in == CHAR_COLON) begin
					phase_d   = PH_COUNT;
					sum_d     = '0;
					low_nib_d = 1'b0;
					seen_d    = '0;
				end else begin
					phase_d = PH_SKIP;
				end
			end else if (phase_q == PH_SKIP) begin
				phase_d = PH_SKIP;
			end else if (!low_nib_q) begin
				byte_d    = {4'd0, nib};
				low_nib_d = 1'b1;
			end else begin
				low_nib_d = 1'b0;
				byte_d    = full_byte;
				case (phase_q)
					PH_COUNT: begin
						len_d   = full_byte;
						sum_d   = sum_q + full_byte;
						phase_d = PH_ADDR_HI;
					end
					PH_ADDR_HI: begin
						addr_d  = {full_byte, 8'd0};
						sum_d   = sum_q + full_byte;
						phase_d = PH_ADDR_LO;
					end
					PH_ADDR_LO: begin
						addr_d  = {addr_q[15:8], full_byte};
						sum_d   = sum_q + full_byte;
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						rkind_d = full_byte;
						sum_d   = sum_q + full_byte;
						seen_d  = '0;
						if (full_byte == REC_DATA) begin
							// A data record never moves the pointer back.
							if (wp_q < target_clamped) begin
								wp_d = target_clamped;
							end
							phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
						end else if (full_byte == REC_EXT_LIN) begin
							addr_d  = '0;
							phase_d = PH_DATA;
						end else begin
							phase_d = PH_SKIP;
						end
					end
					PH_DATA: begin
						sum_d  = sum_q + full_byte;
						seen_d = seen_inc;
						if (rkind_q == REC_EXT_LIN) begin
							// Exactly two segment bytes are read, whatever the count says.
							addr_d = {addr_q[7:0], full_byte};
							if (seen_inc >= 8'd2) begin
								phase_d = PH_CHECK;
							end
						end else begin
							if (seen_inc == len_q) begin
								phase_d = PH_CHECK;
							end
							emit      = 1'b1;
							emit_kind = KIND_WRITE;
							emit_data = full_byte;
							if (wp_q >= IMAGE_LEN) begin
								emit_oor = 1'b1;
							end else begin
								emit_addr = wp_q[ADDR_W-1:0];
								wp_d      = wp_q + LEN_W'(1);
							end
						end
					end
					PH_CHECK: begin
						phase_d = PH_SKIP;
						emit    = 1'b1;
						if ((sum_q + full_byte) != 8'd0) begin
							wp_d      = '0;
							halted_d  = 1'b1;
							emit_kind = KIND_CSUM_ERR;
						end else if (rkind_q == REC_EXT_LIN) begin
							seg_d = addr_q;
							if (addr_q > 16'd1) begin
								halted_d  = 1'b1;
								emit_kind = KIND_HIGH_SEG;
							end
						end
					end
					default: begin
						phase_d = PH_SKIP;
					end
				endcase
			end
		end
	end

	// Parse state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LINE_START;
			low_nib_q   <= 1'b0;
			byte_q      <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			addr_q      <= '0;
			rkind_q     <= '0;
			seen_q      <= '0;
			seg_q       <= '0;
			wp_q        <= '0;
			halted_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result takes the register even when the old one leaves in this cycle.
			if (accept && emit) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				phase_q   <= phase_d;
				low_nib_q <= low_nib_d;
				byte_q    <= byte_d;
				sum_q     <= sum_d;
				len_q     <= len_d;
				addr_q    <= addr_d;
				rkind_q   <= rkind_d;
				seen_q    <= seen_d;
				seg_q     <= seg_d;
				wp_q      <= wp_d;
				halted_q  <= halted_d;
			end
		end
	end

	// Result payload needs no reset; it is qualified by the valid flag.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_kind_q <= emit_kind;
			res_addr_q <= emit_addr;
			res_data_q <= emit_data;
			res_oor_q  <= emit_oor;
			res_len_q  <= wp_d;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.kind         = res_kind_q;
	assign results.write_addr   = res_addr_q;
	assign results.write_data   = res_data_q;
	assign results.out_of_range = res_oor_q;
	assign results.image_length = res_len_q;

endmodule
